>>> hw/rtl/bcqo_pkg.sv
// shared types and constants of the cropped quad occupancy check
package bcqo_pkg;

  // classified word passed from the front part to the back part
  typedef struct packed {
    logic hit;
    logic last;
  } word_t;

  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int VERTEX_W    = 32;
  localparam int BOX_W       = 48;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_FOUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LOWER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_UPPER    = 3'd5;

endpackage

>>> hw/rtl/box_cropped_quad_occupancy_check.sv
// top level of the cropped quad occupancy check
//
//   channel  ports                                    handshake
//   in       in_point_x/y/z, in_point_valid,          in_push / in_full
//            in_frame_last
//   out      out_space_free                           out_pop / out_empty
//   cfg      cfg_index, cfg_wdata                     cfg_we
//
// one point per cycle while in_full is low; a word passes a three-stage front
// pipeline (register, box test and differences, products), then the queue and
// the back part, where a frame result is registered before it shows on out.
// in_full rises when the queue plus the words in the front pipeline reach the
// queue depth; only a stalled result holds the queue. reset is synchronous.
module box_cropped_quad_occupancy_check #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [COORD_BITS-1:0]        in_point_x,
  input  logic signed [COORD_BITS-1:0]        in_point_y,
  input  logic signed [COORD_BITS-1:0]        in_point_z,
  input  logic                                in_point_valid,
  input  logic                                in_frame_last,
  input  logic                                out_pop,
  output logic                                out_empty,
  output logic                                out_space_free,
  input  logic                                cfg_we,
  input  logic [bcqo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcqo_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [3:0][bcqo_pkg::VERTEX_W-1:0] vertex_r;
  logic [bcqo_pkg::BOX_W-1:0]         box_lower_r, box_upper_r;
  logic [bcqo_pkg::OCC_W-1:0]         occ_r, occ_nxt;
  logic                               in_acc;
  logic                               q_push, q_pop, q_empty;
  bcqo_pkg::word_t                    q_push_word, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_r    <= '0;
      box_lower_r <= '0;
      box_upper_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcqo_pkg::REG_VERTEX_ONE:   vertex_r[0] <= cfg_wdata[bcqo_pkg::VERTEX_W-1:0];
        bcqo_pkg::REG_VERTEX_TWO:   vertex_r[1] <= cfg_wdata[bcqo_pkg::VERTEX_W-1:0];
        bcqo_pkg::REG_VERTEX_THREE: vertex_r[2] <= cfg_wdata[bcqo_pkg::VERTEX_W-1:0];
        bcqo_pkg::REG_VERTEX_FOUR:  vertex_r[3] <= cfg_wdata[bcqo_pkg::VERTEX_W-1:0];
        bcqo_pkg::REG_BOX_LOWER:    box_lower_r <= cfg_wdata[bcqo_pkg::BOX_W-1:0];
        bcqo_pkg::REG_BOX_UPPER:    box_upper_r <= cfg_wdata[bcqo_pkg::BOX_W-1:0];
        default: ;
      endcase
    end
  end

  // words in the front pipeline and the queue together
  assign in_full = (occ_r == bcqo_pkg::OCC_W'(bcqo_pkg::QUEUE_DEPTH));
  assign in_acc  = in_push && !in_full;

  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !q_pop) occ_nxt = occ_r + 1'b1;
    else if (!in_acc && q_pop) occ_nxt = occ_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) occ_r <= '0;
    else occ_r <= occ_nxt;
  end

  bcqo_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .point_x    (in_point_x),
    .point_y    (in_point_y),
    .point_z    (in_point_z),
    .point_valid(in_point_valid),
    .frame_last (in_frame_last),
    .vertex     (vertex_r),
    .box_lower  (box_lower_r),
    .box_upper  (box_upper_r),
    .push       (q_push),
    .push_word  (q_push_word)
  );

  bcqo_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_word(q_push_word),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  bcqo_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_space_free(out_space_free)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= bcqo_pkg::OCC_W'(bcqo_pkg::QUEUE_DEPTH))
    else $error("word count above queue depth");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("queue popped while empty");

  a_acc_counted: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> occ_r != '0)
    else $error("accepted word not counted");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> occ_r != '0)
    else $error("front pushed a word that was never counted");

endmodule

>>> hw/rtl/bcqo_front.sv
// front pipeline: crop box test and an edge cross product for each of the four quad edges
module bcqo_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   acc,
  input  logic signed [COORD_BITS-1:0]           point_x,
  input  logic signed [COORD_BITS-1:0]           point_y,
  input  logic signed [COORD_BITS-1:0]           point_z,
  input  logic                                   point_valid,
  input  logic                                   frame_last,
  input  logic [3:0][bcqo_pkg::VERTEX_W-1:0]     vertex,
  input  logic [bcqo_pkg::BOX_W-1:0]             box_lower,
  input  logic [bcqo_pkg::BOX_W-1:0]             box_upper,
  output logic                                   push,
  output bcqo_pkg::word_t                        push_word
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  // packed field k of a register, zero beyond bit 63
  function automatic logic signed [COORD_BITS-1:0] fld(input logic [63:0] r, input int k);
    logic [63:0] s;
    s = r >> (k * COORD_BITS);
    return $signed(s[COORD_BITS-1:0]);
  endfunction

  function automatic logic signed [DW-1:0] sx(input logic signed [COORD_BITS-1:0] v);
    return $signed({v[COORD_BITS-1], v});
  endfunction

  logic signed [COORD_BITS-1:0] vx [4];
  logic signed [COORD_BITS-1:0] vy [4];

  // stage 1: registered input word
  logic                         s1_v_r;
  logic signed [COORD_BITS-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic                         s1_pv_r, s1_last_r;

  // stage 2: box test and differences
  logic                 s2_v_r, s2_last_r, s2_cnt_r;
  logic signed [DW-1:0] ex_r [4];
  logic signed [DW-1:0] ey_r [4];
  logic signed [DW-1:0] qx_r [4];
  logic signed [DW-1:0] qy_r [4];
  logic                 inbox;

  // stage 3: products
  logic                 s3_v_r, s3_last_r, s3_cnt_r;
  logic signed [PW-1:0] lp_r [4];
  logic signed [PW-1:0] rp_r [4];
  logic [3:0]           left;

  always_comb begin
    for (int e = 0; e < 4; e++) begin
      vx[e] = fld({32'd0, vertex[e]}, 0);
      vy[e] = fld({32'd0, vertex[e]}, 1);
    end
  end

  assign inbox = s1_pv_r &&
                 s1_x_r >= fld({16'd0, box_lower}, 0) && s1_x_r <= fld({16'd0, box_upper}, 0) &&
                 s1_y_r >= fld({16'd0, box_lower}, 1) && s1_y_r <= fld({16'd0, box_upper}, 1) &&
                 s1_z_r >= fld({16'd0, box_lower}, 2) && s1_z_r <= fld({16'd0, box_upper}, 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_x_r    <= point_x;
      s1_y_r    <= point_y;
      s1_z_r    <= point_z;
      s1_pv_r   <= point_valid;
      s1_last_r <= frame_last;
    end
    s2_last_r <= s1_last_r;
    s2_cnt_r  <= inbox;
    for (int e = 0; e < 4; e++) begin
      ex_r[e] <= sx(vx[(e + 1) % 4]) - sx(vx[e]);
      ey_r[e] <= sx(vy[(e + 1) % 4]) - sx(vy[e]);
      qx_r[e] <= sx(s1_x_r) - sx(vx[e]);
      qy_r[e] <= sx(s1_y_r) - sx(vy[e]);
    end
    s3_last_r <= s2_last_r;
    s3_cnt_r  <= s2_cnt_r;
    for (int e = 0; e < 4; e++) begin
      lp_r[e] <= PW'(ex_r[e]) * PW'(qy_r[e]);
      rp_r[e] <= PW'(ey_r[e]) * PW'(qx_r[e]);
    end
  end

  always_comb begin
    for (int e = 0; e < 4; e++) begin
      left[e] = lp_r[e] > rp_r[e];
    end
  end

  assign push           = s3_v_r;
  assign push_word.hit  = s3_cnt_r & (&left);
  assign push_word.last = s3_last_r;

endmodule

>>> hw/rtl/bcqo_queue.sv
// short word queue between the front and back parts
module bcqo_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bcqo_pkg::word_t push_word,
  input  logic            pop,
  output bcqo_pkg::word_t head,
  output logic            empty
);

  bcqo_pkg::word_t                mem_r [bcqo_pkg::QUEUE_DEPTH];
  logic [bcqo_pkg::PTR_W-1:0]     wr_r, rd_r;
  logic [bcqo_pkg::OCC_W-1:0]     cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_word;
  end

  assign head  = mem_r[rd_r];
  assign empty = (cnt_r == '0);

endmodule

>>> hw/rtl/bcqo_back.sv
// back part: sticky hit flag and the result register
module bcqo_back (
  input  logic            clk,
  input  logic            rst_n,
  input  bcqo_pkg::word_t head,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic            out_pop,
  output logic            out_empty,
  output logic            out_space_free
);

  logic hit_seen_r, hit_seen_nxt;
  logic out_v_r, out_v_nxt;
  logic free_r, free_nxt;
  logic taken;

  assign taken = out_pop && out_v_r;
  // a middle word never waits; a last word needs the result slot
  assign q_pop = !q_empty && (!head.last || !out_v_r || taken);

  always_comb begin
    hit_seen_nxt = hit_seen_r;
    out_v_nxt    = out_v_r && !taken;
    free_nxt     = free_r;
    if (q_pop) begin
      if (head.last) begin
        hit_seen_nxt = 1'b0;
        out_v_nxt    = 1'b1;
        free_nxt     = !(hit_seen_r | head.hit);
      end else begin
        hit_seen_nxt = hit_seen_r | head.hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_seen_r <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      hit_seen_r <= hit_seen_nxt;
      out_v_r    <= out_v_nxt;
    end
    free_r <= free_nxt;
  end

  assign out_empty      = !out_v_r;
  assign out_space_free = free_r;

endmodule
